// ----- rtl/moving_average_filter_defines.svh -----
// ----------------------------------------------------------------------------
// Moving average filter assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef MOVING_AVERAGE_FILTER_DEFINES_SVH
`define MOVING_AVERAGE_FILTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define MAF_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define MAF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/mavg_pkg.sv -----
// ----------------------------------------------------------------------------
// Moving average filter package
// Shared widths, reset values and the divider state type.
// ----------------------------------------------------------------------------
`default_nettype none

package mavg_pkg;

	localparam int SAMPLE_W       = 16;
	localparam int CFG_W          = 6;
	localparam int MAX_WINDOW_DEF = 32;
	localparam int WIN_LEN_RESET  = 8;
	localparam int QUEUE_DEPTH    = 2;   // power of two

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_RUN,
		DIV_DONE
	} div_state_t;

endpackage

`default_nettype wire

// ----- rtl/mavg_front.sv -----
// ----------------------------------------------------------------------------
// Moving average front end
// Takes a sample, swaps it into the circular window and updates the running sum.
// ----------------------------------------------------------------------------
`default_nettype none

module mavg_front #(
	parameter int MAX_WINDOW = mavg_pkg::MAX_WINDOW_DEF,
	localparam int PTR_W = $clog2(MAX_WINDOW),
	localparam int LEN_W = $clog2(MAX_WINDOW + 1),
	localparam int SUM_W = mavg_pkg::SAMPLE_W + PTR_W
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 clear,
	input  wire logic [LEN_W-1:0]                     len,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic signed [mavg_pkg::SAMPLE_W-1:0] sample,
	input  wire logic                                 q_full,
	output logic                                      push,
	output logic signed [SUM_W-1:0]                   push_sum
);

	logic signed [mavg_pkg::SAMPLE_W-1:0] win_mem [MAX_WINDOW];
	logic [MAX_WINDOW-1:0]                win_vld_q;
	logic [PTR_W-1:0]                     pos_q;
	logic signed [SUM_W-1:0]              sum_q;

	logic                                 busy_s1;
	logic signed [mavg_pkg::SAMPLE_W-1:0] sample_s1;
	logic signed [mavg_pkg::SAMPLE_W-1:0] old_s1;
	logic                                 old_vld_s1;

	logic                                 accept;
	logic signed [mavg_pkg::SAMPLE_W-1:0] old_val;
	logic signed [SUM_W-1:0]              sum_nxt;
	logic [LEN_W-1:0]                     pos_inc;
	logic [PTR_W-1:0]                     pos_nxt;

	// one sample in flight; the write lands before the next read
	assign in_ready = !busy_s1 && !q_full;
	assign accept   = in_valid && in_ready;

	assign old_val  = old_vld_s1 ? old_s1 : '0;
	assign sum_nxt  = sum_q + SUM_W'(sample_s1) - SUM_W'(old_val);
	assign pos_inc  = LEN_W'(pos_q) + LEN_W'(1);
	assign pos_nxt  = (pos_inc >= len) ? '0 : PTR_W'(pos_inc);

	assign push     = busy_s1;
	assign push_sum = sum_nxt;

	// window store, no reset
	always_ff @(posedge clk) begin
		if (busy_s1) begin
			win_mem[pos_q] <= sample_s1;
		end
		if (accept) begin
			old_s1 <= win_mem[pos_q];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1    <= 1'b0;
			old_vld_s1 <= 1'b0;
			win_vld_q  <= '0;
			pos_q      <= '0;
			sum_q      <= '0;
		end else if (clear) begin
			busy_s1    <= 1'b0;
			old_vld_s1 <= 1'b0;
			win_vld_q  <= '0;
			pos_q      <= '0;
			sum_q      <= '0;
		end else begin
			busy_s1 <= accept;
			if (accept) begin
				old_vld_s1 <= win_vld_q[pos_q];
			end
			if (busy_s1) begin
				win_vld_q[pos_q] <= 1'b1;
				pos_q            <= pos_nxt;
				sum_q            <= sum_nxt;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/mavg_queue.sv -----
// ----------------------------------------------------------------------------
// Moving average sum queue
// Short FIFO of running sums between the front end and the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module mavg_queue #(
	parameter int DATA_W = 21,
	localparam int DEPTH = mavg_pkg::QUEUE_DEPTH,
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic [DATA_W-1:0] push_data,
	input  wire logic              pop,
	output logic [DATA_W-1:0]      pop_data,
	output logic                   full,
	output logic                   empty
);

	logic [DATA_W-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/mavg_div.sv -----
// ----------------------------------------------------------------------------
// Moving average divider
// Bit-serial signed division of the running sum by the window length.
// ----------------------------------------------------------------------------
`default_nettype none

module mavg_div #(
	parameter int MAX_WINDOW = mavg_pkg::MAX_WINDOW_DEF,
	localparam int PTR_W = $clog2(MAX_WINDOW),
	localparam int LEN_W = $clog2(MAX_WINDOW + 1),
	localparam int SUM_W = mavg_pkg::SAMPLE_W + PTR_W,
	localparam int CNT_W = $clog2(SUM_W)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [LEN_W-1:0]              len,
	input  wire logic                          q_empty,
	input  wire logic signed [SUM_W-1:0]       q_sum,
	output logic                               q_pop,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [mavg_pkg::SAMPLE_W-1:0] average
);

	mavg_pkg::div_state_t state_q, state_nxt;

	logic [SUM_W-1:0] dvd_q;     // dividend bits out the top, quotient in the bottom
	logic [LEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;

	logic             load_div;
	logic             step;
	logic             load_out;
	logic [SUM_W-1:0] mag;
	logic [LEN_W:0]   trial;
	logic             ge;
	logic [LEN_W-1:0] diff;
	logic [SUM_W-1:0] quo_signed;

	assign mag        = q_sum[SUM_W-1] ? (~q_sum + SUM_W'(1)) : q_sum;
	assign trial      = {rem_q, dvd_q[SUM_W-1]};
	assign ge         = (trial >= {1'b0, len});
	// only used when trial >= len, so the difference is below len
	assign diff       = trial[LEN_W-1:0] - len;
	assign quo_signed = neg_q ? (~dvd_q + SUM_W'(1)) : dvd_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			mavg_pkg::DIV_IDLE: begin
				if (!q_empty) begin
					state_nxt = mavg_pkg::DIV_RUN;
				end
			end
			mavg_pkg::DIV_RUN: begin
				if (cnt_q == '0) begin
					state_nxt = mavg_pkg::DIV_DONE;
				end
			end
			mavg_pkg::DIV_DONE: begin
				if (!out_valid || out_ready) begin
					state_nxt = mavg_pkg::DIV_IDLE;
				end
			end
			default: state_nxt = mavg_pkg::DIV_IDLE;
		endcase
	end

	always_comb begin
		load_div = 1'b0;
		step     = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			mavg_pkg::DIV_IDLE: load_div = !q_empty;
			mavg_pkg::DIV_RUN:  step     = 1'b1;
			mavg_pkg::DIV_DONE: load_out = !out_valid || out_ready;
			default: ;
		endcase
	end

	assign q_pop = load_div;

	always_ff @(posedge clk) begin
		if (load_div) begin
			dvd_q <= mag;
			rem_q <= '0;
			neg_q <= q_sum[SUM_W-1];
		end else if (step) begin
			dvd_q <= {dvd_q[SUM_W-2:0], ge};
			rem_q <= ge ? diff : trial[LEN_W-1:0];
		end
		if (load_out) begin
			average <= quo_signed[mavg_pkg::SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= mavg_pkg::DIV_IDLE;
			cnt_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (load_div) begin
				cnt_q <= CNT_W'(SUM_W - 1);
			end else if (step) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (load_out) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/moving_average_filter.sv -----
// ----------------------------------------------------------------------------
// Moving average filter
// Boxcar mean of the last window_length signed 16-bit samples.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready/sample): one transaction per sample.
//  - Output channel (out_valid/out_ready/average): one transaction per
//    sample, in order; average is the window sum divided by the window
//    length, truncated toward zero. Slots not yet filled count as zero.
//  - cfg_we/cfg_wdata write window_length (0 acts as 1, above MAX_WINDOW
//    acts as MAX_WINDOW) and clear the window and the sum. Write only while
//    no transaction is in flight.
//  - Front end takes no new sample while one is in flight (memory read,
//    then sum update and write-back), pushing the sum into a 2-entry queue.
//  - The divider retires one bit per cycle and takes no new sum until its
//    result is in the output register, which sets the sustained rate.
//  - Reset: window length 8, window, sum and write pointer cleared.
//  - When out_ready stays low, the result waits in the output register, the
//    divider holds its next result, then the queue fills and in_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

`include "moving_average_filter_defines.svh"

module moving_average_filter #(
	parameter int MAX_WINDOW = mavg_pkg::MAX_WINDOW_DEF,
	localparam int PTR_W = $clog2(MAX_WINDOW),
	localparam int LEN_W = $clog2(MAX_WINDOW + 1),
	localparam int SUM_W = mavg_pkg::SAMPLE_W + PTR_W
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [mavg_pkg::CFG_W-1:0]           cfg_wdata,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic signed [mavg_pkg::SAMPLE_W-1:0] sample,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic signed [mavg_pkg::SAMPLE_W-1:0]      average
);

	localparam int CMP_W = (mavg_pkg::CFG_W > LEN_W) ? mavg_pkg::CFG_W : LEN_W;

	logic [mavg_pkg::CFG_W-1:0] win_len_q;
	logic [CMP_W-1:0]           len_ext;
	logic [LEN_W-1:0]           eff_len;

	logic                       push;
	logic signed [SUM_W-1:0]    push_sum;
	logic                       q_full;
	logic                       q_empty;
	logic                       q_pop;
	logic [SUM_W-1:0]           q_data;

	// window length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_q <= mavg_pkg::CFG_W'(mavg_pkg::WIN_LEN_RESET);
		end else if (cfg_we) begin
			win_len_q <= cfg_wdata;
		end
	end

	// effective length: zero means one, clamp to window depth
	assign len_ext = CMP_W'(win_len_q);
	always_comb begin
		priority if (len_ext == '0) begin
			eff_len = LEN_W'(1);
		end else if (len_ext > CMP_W'(MAX_WINDOW)) begin
			eff_len = LEN_W'(MAX_WINDOW);
		end else begin
			eff_len = LEN_W'(len_ext);
		end
	end

	mavg_front #(
		.MAX_WINDOW(MAX_WINDOW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (cfg_we),
		.len      (eff_len),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sample   (sample),
		.q_full   (q_full),
		.push     (push),
		.push_sum (push_sum)
	);

	mavg_queue #(
		.DATA_W(SUM_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_sum),
		.pop       (q_pop),
		.pop_data  (q_data),
		.full      (q_full),
		.empty     (q_empty)
	);

	mavg_div #(
		.MAX_WINDOW(MAX_WINDOW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.len       (eff_len),
		.q_empty   (q_empty),
		.q_sum     (q_data),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.average   (average)
	);

	// assertions
	`MAF_ASSERT_SAME(a_no_push_full, push, !q_full || q_pop, "sum pushed into full queue")
	`MAF_ASSERT_SAME(a_no_pop_empty, q_pop, !q_empty, "divider popped empty queue")
	`MAF_ASSERT_NEXT(a_front_gap, in_valid && in_ready, !in_ready && push, "front end overlap")

endmodule

`default_nettype wire
